// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define TPSE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define TPSE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tpse_pkg.sv =====
package tpse_pkg;

    // fixed point widths
    localparam int unsigned QW = 32;
    localparam int unsigned PW = 2 * QW - QW / 2;
    localparam int unsigned WW = 52;

    // port widths
    localparam int unsigned IN_W      = 64;
    localparam int unsigned OUT_W     = 200;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned MAP_W     = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [WW-1:0] wide_t;

    localparam q_t Q_ONE = 32'sh0001_0000;
    localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_GRAD_S_X  = 3'd2,
        REG_GRAD_S_Y  = 3'd3,
        REG_GRAD_T_X  = 3'd4,
        REG_GRAD_T_Y  = 3'd5,
        REG_EDGE_MAP  = 3'd6
    } cfg_reg_t;

    // register contents plus the derived gradient of r
    typedef struct packed {
        q_t               origin_x;
        q_t               origin_y;
        q_t               grad_s_x;
        q_t               grad_s_y;
        q_t               grad_t_x;
        q_t               grad_t_y;
        q_t               grad_r_x;
        q_t               grad_r_y;
        logic [MAP_W-1:0] edge_slot_map;
    } cfg_t;

    function automatic wide_t widen(input q_t v);
        return {{(WW-QW){v[QW-1]}}, v};
    endfunction

    function automatic wide_t widen_p(input prod_t v);
        return {{(WW-PW){v[PW-1]}}, v};
    endfunction

    // clamp to the signed 32 bit range
    function automatic q_t sat_q(input wide_t v);
        q_t res;
        if ((&v[WW-1:QW-1]) || !(|v[WW-1:QW-1]))
            res = v[QW-1:0];
        else if (v[WW-1])
            res = Q_MIN;
        else
            res = Q_MAX;
        return res;
    endfunction

    // q16.16 product, rounded half up by floor
    function automatic prod_t mulq(input q_t a, input q_t b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        p = p + $signed({{(QW+QW/2){1'b0}}, 1'b1, {(QW/2-1){1'b0}}});
        return p[2*QW-1:QW/2];
    endfunction

    // edge slot from a 2 bit map field, a field of three lands on slot five
    function automatic logic [SLOT_W-1:0] edge_slot(input logic [1:0] f);
        logic [SLOT_W-1:0] res;
        if (f == 2'd3)
            res = 3'd5;
        else
            res = 3'd3 + {1'b0, f};
        return res;
    endfunction

endpackage

// ===== rtl/triangle_p2_shape_eval.sv =====
// Quadratic triangle shape functions in signed Q16.16.
// Input stream: one query point per transfer on s_tvalid/s_tready/s_tdata.
// Output stream: six transfers per point on m_tvalid/m_tready/m_tdata, in node
// order vertex r, vertex s, vertex t, edge rs, edge st, edge rt; m_tlast marks
// the sixth. Each result carries node slot, shape value, x and y derivative
// and the barycentric coordinates r, s, t of the point.
// Configuration: cfg_we/cfg_index/cfg_data write vertex zero, the gradients of
// s and t and the edge slot map; write only while no point is in flight.
// Path: a point passes the offset, product and s/t registers of the barycentric
// stage, then the hold, operand, product and result registers of the node stage.
// Throughput: one result per cycle while m_tready stays high, set by the node
// stage that steps a held point over its six nodes through one set of five
// multipliers. Three more points queue in the barycentric stages, so s_tready
// stays high for up to three transfers while a result waits at the output.
// Reset: rst_n clears all valid flags and restores the register defaults
// (vertex zero at the origin, unit gradients, edge slots 3, 4, 5).
// Stall: a low m_tready holds the output and the pipeline behind it; nothing
// is dropped or repeated.
module triangle_p2_shape_eval (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tpse_pkg::IN_W-1:0]      s_tdata,   // point_x, point_y
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // node_slot, shape_value, deriv_x, deriv_y, bary_r, bary_s, bary_t, zero fill
    output logic [tpse_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [tpse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpse_pkg::CFG_W-1:0]     cfg_data
);

    localparam int unsigned PAD_W = tpse_pkg::OUT_W - tpse_pkg::SLOT_W - 6 * tpse_pkg::QW;

    tpse_pkg::cfg_t              cfg;
    logic                        bary_valid;
    logic                        bary_ready;
    tpse_pkg::q_t                bary_s_w;
    tpse_pkg::q_t                bary_t_w;
    logic [tpse_pkg::SLOT_W-1:0] node_slot;
    tpse_pkg::q_t                shape_value;
    tpse_pkg::q_t                deriv_x;
    tpse_pkg::q_t                deriv_y;
    tpse_pkg::q_t                out_r;
    tpse_pkg::q_t                out_s;
    tpse_pkg::q_t                out_t;

    // configuration registers
    tpse_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // barycentric coordinates
    tpse_bary u_bary (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point_x   (s_tdata[tpse_pkg::QW-1:0]),
        .point_y   (s_tdata[2*tpse_pkg::QW-1:tpse_pkg::QW]),
        .out_valid (bary_valid),
        .out_ready (bary_ready),
        .bary_s    (bary_s_w),
        .bary_t    (bary_t_w)
    );

    // per node shape values and derivatives
    tpse_node u_node (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (bary_valid),
        .in_ready    (bary_ready),
        .in_s        (bary_s_w),
        .in_t        (bary_t_w),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .node_slot   (node_slot),
        .shape_value (shape_value),
        .deriv_x     (deriv_x),
        .deriv_y     (deriv_y),
        .bary_r      (out_r),
        .bary_s      (out_s),
        .bary_t      (out_t),
        .last_node   (m_tlast)
    );

    // result packing, first field in the low bits
    assign m_tdata = {{PAD_W{1'b0}}, out_t, out_s, out_r,
                      deriv_y, deriv_x, shape_value, node_slot};

endmodule

// ===== rtl/tpse_cfg.sv =====
module tpse_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpse_pkg::CFG_W-1:0]     cfg_data,
    output tpse_pkg::cfg_t                 cfg
);

    tpse_pkg::q_t                     origin_x_reg;
    tpse_pkg::q_t                     origin_y_reg;
    tpse_pkg::q_t                     grad_s_x_reg;
    tpse_pkg::q_t                     grad_s_y_reg;
    tpse_pkg::q_t                     grad_t_x_reg;
    tpse_pkg::q_t                     grad_t_y_reg;
    tpse_pkg::q_t                     grad_r_x_reg;
    tpse_pkg::q_t                     grad_r_y_reg;
    logic [tpse_pkg::MAP_W-1:0]       edge_map_reg;
    tpse_pkg::q_t                     grad_r_x_next;
    tpse_pkg::q_t                     grad_r_y_next;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            grad_s_x_reg <= tpse_pkg::Q_ONE;
            grad_s_y_reg <= '0;
            grad_t_x_reg <= '0;
            grad_t_y_reg <= tpse_pkg::Q_ONE;
            edge_map_reg <= 6'd36;
        end
        else if (cfg_we)
        begin
            unique case (tpse_pkg::cfg_reg_t'(cfg_index))
                tpse_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                tpse_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                tpse_pkg::REG_GRAD_S_X: grad_s_x_reg <= cfg_data;
                tpse_pkg::REG_GRAD_S_Y: grad_s_y_reg <= cfg_data;
                tpse_pkg::REG_GRAD_T_X: grad_t_x_reg <= cfg_data;
                tpse_pkg::REG_GRAD_T_Y: grad_t_y_reg <= cfg_data;
                tpse_pkg::REG_EDGE_MAP: edge_map_reg <= cfg_data[tpse_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // gradient of r is minus the sum of the other two
    always_comb
    begin
        grad_r_x_next = tpse_pkg::sat_q(-tpse_pkg::widen(grad_s_x_reg)
                                        - tpse_pkg::widen(grad_t_x_reg));
        grad_r_y_next = tpse_pkg::sat_q(-tpse_pkg::widen(grad_s_y_reg)
                                        - tpse_pkg::widen(grad_t_y_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grad_r_x_reg <= -tpse_pkg::Q_ONE;
            grad_r_y_reg <= -tpse_pkg::Q_ONE;
        end
        else
        begin
            grad_r_x_reg <= grad_r_x_next;
            grad_r_y_reg <= grad_r_y_next;
        end
    end

    assign cfg.origin_x      = origin_x_reg;
    assign cfg.origin_y      = origin_y_reg;
    assign cfg.grad_s_x      = grad_s_x_reg;
    assign cfg.grad_s_y      = grad_s_y_reg;
    assign cfg.grad_t_x      = grad_t_x_reg;
    assign cfg.grad_t_y      = grad_t_y_reg;
    assign cfg.grad_r_x      = grad_r_x_reg;
    assign cfg.grad_r_y      = grad_r_y_reg;
    assign cfg.edge_slot_map = edge_map_reg;

endmodule

// ===== rtl/tpse_bary.sv =====
module tpse_bary (
    input  logic           clk,
    input  logic           rst_n,
    input  tpse_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  tpse_pkg::q_t   point_x,
    input  tpse_pkg::q_t   point_y,
    output logic           out_valid,
    input  logic           out_ready,
    output tpse_pkg::q_t   bary_s,
    output tpse_pkg::q_t   bary_t
);

    logic            f1_v_reg;
    logic            f2_v_reg;
    logic            f3_v_reg;
    logic            f1_rdy;
    logic            f2_rdy;
    logic            f3_rdy;
    tpse_pkg::q_t    dx_reg;
    tpse_pkg::q_t    dy_reg;
    tpse_pkg::q_t    dx_next;
    tpse_pkg::q_t    dy_next;
    tpse_pkg::prod_t p_sx_reg;
    tpse_pkg::prod_t p_sy_reg;
    tpse_pkg::prod_t p_tx_reg;
    tpse_pkg::prod_t p_ty_reg;
    tpse_pkg::prod_t p_sx_next;
    tpse_pkg::prod_t p_sy_next;
    tpse_pkg::prod_t p_tx_next;
    tpse_pkg::prod_t p_ty_next;
    tpse_pkg::q_t    s_reg;
    tpse_pkg::q_t    t_reg;
    tpse_pkg::q_t    s_next;
    tpse_pkg::q_t    t_next;

    // a stage takes new data when empty or when its successor moves
    assign f3_rdy   = !f3_v_reg || out_ready;
    assign f2_rdy   = !f2_v_reg || f3_rdy;
    assign f1_rdy   = !f1_v_reg || f2_rdy;
    assign in_ready = f1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            if (f1_rdy)
                f1_v_reg <= in_valid;
            if (f2_rdy)
                f2_v_reg <= f1_v_reg;
            if (f3_rdy)
                f3_v_reg <= f2_v_reg;
        end
    end

    // offset from vertex zero
    always_comb
    begin
        dx_next = tpse_pkg::sat_q(tpse_pkg::widen(point_x) - tpse_pkg::widen(cfg.origin_x));
        dy_next = tpse_pkg::sat_q(tpse_pkg::widen(point_y) - tpse_pkg::widen(cfg.origin_y));
    end

    // four gradient products
    always_comb
    begin
        p_sx_next = tpse_pkg::mulq(cfg.grad_s_x, dx_reg);
        p_sy_next = tpse_pkg::mulq(cfg.grad_s_y, dy_reg);
        p_tx_next = tpse_pkg::mulq(cfg.grad_t_x, dx_reg);
        p_ty_next = tpse_pkg::mulq(cfg.grad_t_y, dy_reg);
    end

    // s and t
    always_comb
    begin
        s_next = tpse_pkg::sat_q(tpse_pkg::widen_p(p_sx_reg) + tpse_pkg::widen_p(p_sy_reg));
        t_next = tpse_pkg::sat_q(tpse_pkg::widen_p(p_tx_reg) + tpse_pkg::widen_p(p_ty_reg));
    end

    always_ff @(posedge clk)
    begin
        if (f1_rdy && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (f2_rdy && f1_v_reg)
        begin
            p_sx_reg <= p_sx_next;
            p_sy_reg <= p_sy_next;
            p_tx_reg <= p_tx_next;
            p_ty_reg <= p_ty_next;
        end
        if (f3_rdy && f2_v_reg)
        begin
            s_reg <= s_next;
            t_reg <= t_next;
        end
    end

    assign out_valid = f3_v_reg;
    assign bary_s    = s_reg;
    assign bary_t    = t_reg;

endmodule

// ===== rtl/tpse_node.sv =====
module tpse_node (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpse_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tpse_pkg::q_t                in_s,
    input  tpse_pkg::q_t                in_t,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tpse_pkg::SLOT_W-1:0] node_slot,
    output tpse_pkg::q_t                shape_value,
    output tpse_pkg::q_t                deriv_x,
    output tpse_pkg::q_t                deriv_y,
    output tpse_pkg::q_t                bary_r,
    output tpse_pkg::q_t                bary_s,
    output tpse_pkg::q_t                bary_t,
    output logic                        last_node
);

    localparam int unsigned NOPS = 5;

    // node order of the six results
    typedef enum logic [2:0] {
        NODE_R  = 3'd0,
        NODE_S  = 3'd1,
        NODE_T  = 3'd2,
        NODE_RS = 3'd3,
        NODE_ST = 3'd4,
        NODE_RT = 3'd5
    } node_t;

    localparam logic [tpse_pkg::SLOT_W-1:0] SLOT_R = 3'd0;
    localparam logic [tpse_pkg::SLOT_W-1:0] SLOT_S = 3'd1;
    localparam logic [tpse_pkg::SLOT_W-1:0] SLOT_T = 3'd2;

    // hold stage: one point, stepped over its six nodes
    logic                        h_v_reg;
    node_t                       cnt_reg;
    node_t                       cnt_next;
    tpse_pkg::q_t                hr_reg;
    tpse_pkg::q_t                hs_reg;
    tpse_pkg::q_t                ht_reg;
    tpse_pkg::q_t                hr_next;
    logic                        h_fire;
    logic                        h_done;

    // operand stage
    logic                        n1_v_reg;
    logic                        n1_rdy;
    tpse_pkg::q_t                op_a_reg [NOPS];
    tpse_pkg::q_t                op_b_reg [NOPS];
    tpse_pkg::q_t                op_a_next [NOPS];
    tpse_pkg::q_t                op_b_next [NOPS];
    logic                        n1_is_edge_reg;
    logic                        n1_is_edge_next;
    logic [tpse_pkg::SLOT_W-1:0] n1_slot_reg;
    logic [tpse_pkg::SLOT_W-1:0] n1_slot_next;
    logic                        n1_last_reg;
    tpse_pkg::q_t                n1_r_reg;
    tpse_pkg::q_t                n1_s_reg;
    tpse_pkg::q_t                n1_t_reg;

    // product stage
    logic                        n2_v_reg;
    logic                        n2_rdy;
    tpse_pkg::prod_t             m_reg [NOPS];
    tpse_pkg::prod_t             m_next [NOPS];
    logic                        n2_is_edge_reg;
    logic [tpse_pkg::SLOT_W-1:0] n2_slot_reg;
    logic                        n2_last_reg;
    tpse_pkg::q_t                n2_r_reg;
    tpse_pkg::q_t                n2_s_reg;
    tpse_pkg::q_t                n2_t_reg;

    // result stage, doubles as the output register
    logic                        n3_v_reg;
    logic                        n3_rdy;
    tpse_pkg::q_t                shape_reg;
    tpse_pkg::q_t                dx_reg;
    tpse_pkg::q_t                dy_reg;
    tpse_pkg::q_t                shape_next;
    tpse_pkg::q_t                dx_next;
    tpse_pkg::q_t                dy_next;
    logic [tpse_pkg::SLOT_W-1:0] n3_slot_reg;
    logic                        n3_last_reg;
    tpse_pkg::q_t                n3_r_reg;
    tpse_pkg::q_t                n3_s_reg;
    tpse_pkg::q_t                n3_t_reg;

    // selected node operands
    tpse_pkg::q_t                u;
    tpse_pkg::q_t                v;
    tpse_pkg::q_t                gux;
    tpse_pkg::q_t                guy;
    tpse_pkg::q_t                gvx;
    tpse_pkg::q_t                gvy;
    tpse_pkg::q_t                two_u;
    tpse_pkg::q_t                four_u;
    tpse_pkg::wide_t             sum_x;
    tpse_pkg::wide_t             sum_y;
    tpse_pkg::wide_t             val_w;

    // ready chain
    assign n3_rdy   = !n3_v_reg || out_ready;
    assign n2_rdy   = !n2_v_reg || n3_rdy;
    assign n1_rdy   = !n1_v_reg || n2_rdy;
    assign h_fire   = h_v_reg && n1_rdy;
    assign h_done   = h_fire && (cnt_reg == NODE_RT);
    assign in_ready = !h_v_reg || h_done;

    // node counter
    always_comb
    begin
        unique case (cnt_reg)
            NODE_R:  cnt_next = NODE_S;
            NODE_S:  cnt_next = NODE_T;
            NODE_T:  cnt_next = NODE_RS;
            NODE_RS: cnt_next = NODE_ST;
            NODE_ST: cnt_next = NODE_RT;
            default: cnt_next = NODE_R;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_v_reg  <= 1'b0;
            cnt_reg  <= NODE_R;
            n1_v_reg <= 1'b0;
            n2_v_reg <= 1'b0;
            n3_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                h_v_reg <= in_valid;
            if (in_valid && in_ready)
                cnt_reg <= NODE_R;
            else if (h_fire)
                cnt_reg <= cnt_next;
            if (n1_rdy)
                n1_v_reg <= h_v_reg;
            if (n2_rdy)
                n2_v_reg <= n1_v_reg;
            if (n3_rdy)
                n3_v_reg <= n2_v_reg;
        end
    end

    // r from s and t on capture
    assign hr_next = tpse_pkg::sat_q(tpse_pkg::widen(tpse_pkg::Q_ONE)
                                     - tpse_pkg::widen(in_s) - tpse_pkg::widen(in_t));

    // pick coordinates and gradients of the current node
    always_comb
    begin
        u               = hr_reg;
        v               = hs_reg;
        gux             = cfg.grad_r_x;
        guy             = cfg.grad_r_y;
        gvx             = cfg.grad_s_x;
        gvy             = cfg.grad_s_y;
        n1_is_edge_next = 1'b0;
        n1_slot_next    = SLOT_R;
        case (cnt_reg)
            NODE_R: ;
            NODE_S:
            begin
                u            = hs_reg;
                gux          = cfg.grad_s_x;
                guy          = cfg.grad_s_y;
                n1_slot_next = SLOT_S;
            end
            NODE_T:
            begin
                u            = ht_reg;
                gux          = cfg.grad_t_x;
                guy          = cfg.grad_t_y;
                n1_slot_next = SLOT_T;
            end
            NODE_RS:
            begin
                n1_is_edge_next = 1'b1;
                n1_slot_next    = tpse_pkg::edge_slot(cfg.edge_slot_map[1:0]);
            end
            NODE_ST:
            begin
                u               = hs_reg;
                v               = ht_reg;
                gux             = cfg.grad_s_x;
                guy             = cfg.grad_s_y;
                gvx             = cfg.grad_t_x;
                gvy             = cfg.grad_t_y;
                n1_is_edge_next = 1'b1;
                n1_slot_next    = tpse_pkg::edge_slot(cfg.edge_slot_map[3:2]);
            end
            NODE_RT:
            begin
                v               = ht_reg;
                gvx             = cfg.grad_t_x;
                gvy             = cfg.grad_t_y;
                n1_is_edge_next = 1'b1;
                n1_slot_next    = tpse_pkg::edge_slot(cfg.edge_slot_map[5:4]);
            end
            default: ;
        endcase
    end

    // operand pairs: vertex u(2u-1), (4u-1)grad u; edge uv, u grad v + v grad u
    always_comb
    begin
        two_u  = tpse_pkg::sat_q(tpse_pkg::widen(u) + tpse_pkg::widen(u)
                                 - tpse_pkg::widen(tpse_pkg::Q_ONE));
        four_u = tpse_pkg::sat_q((tpse_pkg::widen(u) <<< 2)
                                 - tpse_pkg::widen(tpse_pkg::Q_ONE));
        if (n1_is_edge_next)
        begin
            op_a_next[0] = u;      op_b_next[0] = v;
            op_a_next[1] = u;      op_b_next[1] = gvx;
            op_a_next[2] = v;      op_b_next[2] = gux;
            op_a_next[3] = u;      op_b_next[3] = gvy;
            op_a_next[4] = v;      op_b_next[4] = guy;
        end
        else
        begin
            op_a_next[0] = u;      op_b_next[0] = two_u;
            op_a_next[1] = four_u; op_b_next[1] = gux;
            op_a_next[2] = '0;     op_b_next[2] = '0;
            op_a_next[3] = four_u; op_b_next[3] = guy;
            op_a_next[4] = '0;     op_b_next[4] = '0;
        end
    end

    // five products in parallel
    always_comb
    begin
        for (int i = 0; i < NOPS; i++)
            m_next[i] = tpse_pkg::mulq(op_a_reg[i], op_b_reg[i]);
    end

    // sums, factor four on edges, clamp
    always_comb
    begin
        val_w = tpse_pkg::widen_p(m_reg[0]);
        sum_x = tpse_pkg::widen_p(m_reg[1]) + tpse_pkg::widen_p(m_reg[2]);
        sum_y = tpse_pkg::widen_p(m_reg[3]) + tpse_pkg::widen_p(m_reg[4]);
        if (n2_is_edge_reg)
        begin
            val_w = val_w <<< 2;
            sum_x = sum_x <<< 2;
            sum_y = sum_y <<< 2;
        end
        shape_next = tpse_pkg::sat_q(val_w);
        dx_next    = tpse_pkg::sat_q(sum_x);
        dy_next    = tpse_pkg::sat_q(sum_y);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hr_reg <= hr_next;
            hs_reg <= in_s;
            ht_reg <= in_t;
        end
        if (h_fire)
        begin
            for (int i = 0; i < NOPS; i++)
            begin
                op_a_reg[i] <= op_a_next[i];
                op_b_reg[i] <= op_b_next[i];
            end
            n1_is_edge_reg <= n1_is_edge_next;
            n1_slot_reg    <= n1_slot_next;
            n1_last_reg    <= (cnt_reg == NODE_RT);
            n1_r_reg       <= hr_reg;
            n1_s_reg       <= hs_reg;
            n1_t_reg       <= ht_reg;
        end
        if (n2_rdy && n1_v_reg)
        begin
            for (int i = 0; i < NOPS; i++)
                m_reg[i] <= m_next[i];
            n2_is_edge_reg <= n1_is_edge_reg;
            n2_slot_reg    <= n1_slot_reg;
            n2_last_reg    <= n1_last_reg;
            n2_r_reg       <= n1_r_reg;
            n2_s_reg       <= n1_s_reg;
            n2_t_reg       <= n1_t_reg;
        end
        if (n3_rdy && n2_v_reg)
        begin
            shape_reg   <= shape_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            n3_slot_reg <= n2_slot_reg;
            n3_last_reg <= n2_last_reg;
            n3_r_reg    <= n2_r_reg;
            n3_s_reg    <= n2_s_reg;
            n3_t_reg    <= n2_t_reg;
        end
    end

    assign out_valid   = n3_v_reg;
    assign node_slot   = n3_slot_reg;
    assign shape_value = shape_reg;
    assign deriv_x     = dx_reg;
    assign deriv_y     = dy_reg;
    assign bary_r      = n3_r_reg;
    assign bary_s      = n3_s_reg;
    assign bary_t      = n3_t_reg;
    assign last_node   = n3_last_reg;

endmodule

// ===== rtl/tpse_checker.sv =====
`include "assert_macros.svh"

module tpse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tpse_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // a stalled result stays put
    `TPSE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // node slots never leave the six legal values
    `TPSE_ASSERT(a_slot_range, m_tvalid |-> m_tdata[2:0] <= 3'd5, "node slot out of range")

    // the last result of a point is an edge node
    `TPSE_ASSERT(a_last_edge, m_tvalid && m_tlast |-> m_tdata[2:0] >= 3'd3, "last result not on an edge slot")

    // nothing offered while reset is held
    `TPSE_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind triangle_p2_shape_eval tpse_checker u_tpse_checker (.*);

// ===== tb/triangle_p2_shape_eval_test.sv =====
`timescale 1ns / 1ps

module triangle_p2_shape_eval_test;

    import tpse_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 50;

    // one expected node result
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       shape;
        logic [31:0]       der_x;
        logic [31:0]       der_y;
        logic [31:0]       r;
        logic [31:0]       s;
        logic [31:0]       t;
        logic              last;
    } node_res_t;

    // shape function predictor and in-order result checker
    class shape_board;
        logic [31:0]      org_x, org_y, gs_x, gs_y, gt_x, gt_y;
        logic [MAP_W-1:0] slot_map;
        node_res_t        expected_nodes[$];
        int               n_errors;
        int               n_points;
        int               n_results;

        function new();
            org_x = '0;
            org_y = '0;
            gs_x = Q_ONE;
            gs_y = '0;
            gt_x = '0;
            gt_y = Q_ONE;
            slot_map = 6'd36;
            n_errors = 0;
            n_points = 0;
            n_results = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] v);
            case (idx)
                REG_ORIGIN_X: org_x = v;
                REG_ORIGIN_Y: org_y = v;
                REG_GRAD_S_X: gs_x = v;
                REG_GRAD_S_Y: gs_y = v;
                REG_GRAD_T_X: gt_x = v;
                REG_GRAD_T_Y: gt_y = v;
                REG_EDGE_MAP: slot_map = v[MAP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // exact product, round half up, floor shift back to q16.16
        function longint q_mul(longint a, longint b);
            return (a * b + 64'sd32768) >>> 16;
        endfunction

        // a map field of three saturates to the last edge slot
        function logic [SLOT_W-1:0] map_slot(logic [1:0] f);
            if (f == 2'd3)
                return 3'd5;
            return 3'd3 + {1'b0, f};
        endfunction

        function void push_node(logic [SLOT_W-1:0] slot, longint n, longint nx, longint ny,
                                longint r, longint s, longint t, logic last);
            node_res_t e;
            e.slot = slot;
            e.shape = 32'(clamp32(n));
            e.der_x = 32'(clamp32(nx));
            e.der_y = 32'(clamp32(ny));
            e.r = 32'(clamp32(r));
            e.s = 32'(clamp32(s));
            e.t = 32'(clamp32(t));
            e.last = last;
            expected_nodes.push_back(e);
        endfunction

        // six node results of one accepted point
        function void predict_point(logic [31:0] px, logic [31:0] py);
            longint sx, sy, tx, ty, rx, ry, dx, dy, s, t, r, a, b, c;
            sx = longint'($signed(gs_x));
            sy = longint'($signed(gs_y));
            tx = longint'($signed(gt_x));
            ty = longint'($signed(gt_y));
            rx = clamp32(-sx - tx);
            ry = clamp32(-sy - ty);
            dx = clamp32(longint'($signed(px)) - longint'($signed(org_x)));
            dy = clamp32(longint'($signed(py)) - longint'($signed(org_y)));
            s = clamp32(q_mul(sx, dx) + q_mul(sy, dy));
            t = clamp32(q_mul(tx, dx) + q_mul(ty, dy));
            r = clamp32(64'sd65536 - s - t);
            a = clamp32(4 * r - 64'sd65536);
            b = clamp32(4 * s - 64'sd65536);
            c = clamp32(4 * t - 64'sd65536);
            n_points++;
            // vertex nodes
            push_node(3'd0, q_mul(r, clamp32(2 * r - 64'sd65536)), q_mul(a, rx), q_mul(a, ry),
                      r, s, t, 1'b0);
            push_node(3'd1, q_mul(s, clamp32(2 * s - 64'sd65536)), q_mul(b, sx), q_mul(b, sy),
                      r, s, t, 1'b0);
            push_node(3'd2, q_mul(t, clamp32(2 * t - 64'sd65536)), q_mul(c, tx), q_mul(c, ty),
                      r, s, t, 1'b0);
            // edge nodes rs, st, rt
            push_node(map_slot(slot_map[1:0]), 4 * q_mul(r, s),
                      4 * (q_mul(r, sx) + q_mul(s, rx)), 4 * (q_mul(r, sy) + q_mul(s, ry)),
                      r, s, t, 1'b0);
            push_node(map_slot(slot_map[3:2]), 4 * q_mul(s, t),
                      4 * (q_mul(s, tx) + q_mul(t, sx)), 4 * (q_mul(s, ty) + q_mul(t, sy)),
                      r, s, t, 1'b0);
            push_node(map_slot(slot_map[5:4]), 4 * q_mul(r, t),
                      4 * (q_mul(t, rx) + q_mul(r, tx)), 4 * (q_mul(t, ry) + q_mul(r, ty)),
                      r, s, t, 1'b1);
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
            end
        endfunction

        function void check_node(logic [OUT_W-1:0] data, logic last);
            node_res_t e;
            n_results++;
            if (expected_nodes.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, got %h last %b",
                             $time, data, last);
                return;
            end
            e = expected_nodes.pop_front();
            compare("node_slot", 32'(e.slot), 32'(data[SLOT_W-1:0]));
            compare("shape_value", e.shape, data[3 +: 32]);
            compare("deriv_x", e.der_x, data[35 +: 32]);
            compare("deriv_y", e.der_y, data[67 +: 32]);
            compare("bary_r", e.r, data[99 +: 32]);
            compare("bary_s", e.s, data[131 +: 32]);
            compare("bary_t", e.t, data[163 +: 32]);
            compare("last_node", 32'(e.last), 32'(last));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b1;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;   // point_x, point_y
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // node_slot, shape_value, deriv_x, deriv_y, bary_r, bary_s, bary_t, zero fill
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    shape_board board;
    int src_quiet = 0;
    int sink_quiet = 0;
    int sink_hold = 0;
    int idle_cycles = 0;
    int setup_count = 0;

    triangle_p2_shape_eval dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // idle cycles before the next transfer, with occasional stretches of none
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [31:0] pick_edge_value();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // mostly near the given vertex, some full range, some extremes
    function automatic logic [31:0] pick_coord(logic [31:0] center);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: return $urandom;
            4, 5: return pick_edge_value();
            default: return center + 32'($urandom_range(0, 6 * 65536)) - 32'(3 * 65536);
        endcase
    endfunction

    // result side: check every transfer, then stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                board.check_node(m_tdata, m_tlast);
                sink_hold = draw_gap(sink_quiet);
                m_tready <= (sink_hold == 0);
            end
            else if (!m_tready)
            begin
                if (sink_hold != 0)
                    sink_hold = sink_hold - 1;
                if (sink_hold == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, board.expected_nodes.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_point(input logic [31:0] px, input logic [31:0] py);
        int gap;
        gap = draw_gap(src_quiet);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.predict_point(px, py);
    endtask

    // hold off the source until every pending result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.expected_nodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        board.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic load_setup(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] tx, input logic [31:0] ty,
                              input logic [MAP_W-1:0] map);
        put_reg(REG_ORIGIN_X, ox);
        put_reg(REG_ORIGIN_Y, oy);
        put_reg(REG_GRAD_S_X, sx);
        put_reg(REG_GRAD_S_Y, sy);
        put_reg(REG_GRAD_T_X, tx);
        put_reg(REG_GRAD_T_Y, ty);
        put_reg(REG_EDGE_MAP, 32'(map));
        cfg_we <= 1'b0;
        setup_count++;
    endtask

    // tame setups give meaningful shapes, wild ones push saturation
    task automatic random_setup(input bit wild);
        logic [31:0] v[6];
        for (int i = 0; i < 6; i++)
        begin
            if (wild)
                v[i] = ($urandom_range(0, 2) == 0) ? pick_edge_value() : $urandom;
            else if (i < 2)
                v[i] = 32'($urandom_range(0, 16 * 65536)) - 32'(8 * 65536);
            else
                v[i] = 32'($urandom_range(0, 4 * 65536)) - 32'(2 * 65536);
        end
        load_setup(v[0], v[1], v[2], v[3], v[4], v[5], MAP_W'($urandom_range(0, 63)));
    endtask

    task automatic random_points(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_point(pick_coord(board.org_x), pick_coord(board.org_y));
            if (i == count / 2 && $urandom_range(0, 1) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        board = new();
        // falling edge at time zero starts the asynchronous reset
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: unit triangle at the origin, corners, midpoints, extremes
        send_point(32'd0, 32'd0);
        send_point(Q_ONE, 32'd0);
        send_point(32'd0, Q_ONE);
        send_point(32'h0000_8000, 32'd0);
        send_point(32'h0000_8000, 32'h0000_8000);
        send_point(32'd0, 32'h0000_8000);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MIN);
        send_point(32'hffff_ffff, 32'hffff_ffff);
        drain_results();

        // extreme registers, every map field three so all edges share slot five
        load_setup(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 6'd63);
        send_point(Q_MIN, Q_MAX);
        send_point(32'd0, 32'd0);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MAX, Q_MAX);
        drain_results();

        // all edges on slot three, steep gradients, shifted vertex
        load_setup(32'hfffe_0000, 32'h0003_0000, 32'h0004_0000, 32'hfffc_0000,
                   32'hfffc_0000, 32'h0000_4000, 6'd0);
        send_point(32'hfffe_0000, 32'h0003_0000);
        send_point(32'hffff_0000, 32'h0002_8000);
        send_point(32'h0001_0000, 32'h0000_0000);
        send_point(Q_MIN, Q_MAX);
        send_point(32'h0000_0001, 32'h8000_0001);
        drain_results();

        // random setups and points
        for (int ph = 0; ph < 6; ph++)
        begin
            random_setup(ph % 2 == 1);
            random_points(24);
            drain_results();
        end

        $display("covered %0d points and %0d node results under %0d register setups",
                 board.n_points, board.n_results, setup_count + 1);
        $display("with extreme, saturating and duplicate edge slot settings");
        if (board.n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
